/* src/lidar_planar_point_classifier_macros.svh */
// assertion helpers for the planar point classifier
`ifndef LIDAR_PLANAR_POINT_CLASSIFIER_MACROS_SVH
`define LIDAR_PLANAR_POINT_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LPPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lppc_pkg.sv */
package lppc_pkg;

    localparam int HALF_WINDOW = 2;
    localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
    localparam int FILL_W      = $clog2(WIN_LEN + 1);
    localparam int STRIDE      = 4;
    localparam int PHASE_W     = $clog2(STRIDE);

    localparam int COORD_W     = 24;
    localparam int INTENS_W    = 16;
    localparam int LIMIT_I_W   = 16;
    localparam int LIMIT_G_W   = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    // candidate queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_LIMIT  = 2'd1;

    localparam logic [LIMIT_I_W-1:0] INTENSITY_LIMIT_RST = 16'd77;
    localparam logic [LIMIT_G_W-1:0] GRADIENT_LIMIT_RST  = 24'd102;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic        [INTENS_W-1:0] intensity;
        logic                       intensity_valid;
        logic                       region_start;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  plane_x;
        logic signed [COORD_W-1:0]  plane_y;
        logic signed [COORD_W-1:0]  plane_z;
        logic        [INTENS_W-1:0] plane_intensity;
        logic                       plane_intensity_valid;
    } plane_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic        [INTENS_W-1:0] intensity;
        logic                       intensity_valid;
    } win_entry_t;

    typedef struct packed {
        logic                valid;
        logic [INTENS_W-1:0] value;
    } bright_t;

    // one tested window center with everything the check needs
    typedef struct packed {
        win_entry_t                    center;
        logic signed [COORD_W-1:0]     z_prev;
        logic signed [COORD_W-1:0]     z_next;
        bright_t [WIN_LEN-1:0]         bright;
    } cand_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* src/lppc_front.sv */
module lppc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  lppc_pkg::point_t point,
    input  logic             point_valid,
    input  logic             point_ready,
    output lppc_pkg::cand_t  cand,
    output logic             cand_push
);

    lppc_pkg::win_entry_t win_reg [lppc_pkg::WIN_LEN];
    lppc_pkg::win_entry_t win_next [lppc_pkg::WIN_LEN];

    logic [lppc_pkg::FILL_W-1:0]  fill_reg, fill_next, fill_base;
    logic [lppc_pkg::PHASE_W-1:0] phase_reg, phase_next, phase_base;
    logic                         accept, full, test;

    assign accept = point_valid && point_ready;

    // window after this point shifts in
    always_comb
    begin
        for (int k = 0; k < lppc_pkg::WIN_LEN - 1; k++)
        begin
            win_next[k] = win_reg[k+1];
        end
        win_next[lppc_pkg::WIN_LEN-1].x               = point.pos_x;
        win_next[lppc_pkg::WIN_LEN-1].y               = point.pos_y;
        win_next[lppc_pkg::WIN_LEN-1].z               = point.pos_z;
        win_next[lppc_pkg::WIN_LEN-1].intensity       = point.intensity;
        win_next[lppc_pkg::WIN_LEN-1].intensity_valid = point.intensity_valid;
    end

    // region start restarts fill and stride
    always_comb
    begin
        fill_base  = point.region_start ? '0 : fill_reg;
        phase_base = point.region_start ? '0 : phase_reg;
        if (fill_base < lppc_pkg::FILL_W'(lppc_pkg::WIN_LEN))
        begin
            fill_next = fill_base + 1'b1;
        end
        else
        begin
            fill_next = fill_base;
        end
        full       = (fill_next == lppc_pkg::FILL_W'(lppc_pkg::WIN_LEN));
        test       = full && (phase_base == '0);
        phase_next = full ? phase_base + 1'b1 : phase_base;
    end

    always_comb
    begin
        cand.center = win_next[lppc_pkg::HALF_WINDOW];
        cand.z_prev = win_next[0].z;
        cand.z_next = win_next[lppc_pkg::WIN_LEN-1].z;
        for (int k = 0; k < lppc_pkg::WIN_LEN; k++)
        begin
            cand.bright[k].valid = win_next[k].intensity_valid;
            cand.bright[k].value = win_next[k].intensity;
        end
    end

    assign cand_push = accept && test;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            phase_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < lppc_pkg::WIN_LEN; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

/* src/lppc_queue.sv */
module lppc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  lppc_pkg::cand_t     push_data,
    input  logic                push,
    input  logic                pop,
    output lppc_pkg::cand_t     head,
    output lppc_pkg::q_status_t status
);

    lppc_pkg::cand_t mem [lppc_pkg::QUEUE_DEPTH];

    logic [lppc_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [lppc_pkg::QCNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == lppc_pkg::QCNT_W'(lppc_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/lppc_back.sv */
module lppc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lppc_pkg::cand_t                     cand,
    input  logic                                cand_avail,
    output logic                                cand_pop,
    input  logic [lppc_pkg::LIMIT_I_W-1:0]      intensity_limit,
    input  logic [lppc_pkg::LIMIT_G_W-1:0]      gradient_limit,
    output lppc_pkg::plane_t                    plane,
    output logic                                plane_valid,
    input  logic                                plane_ready
);

    typedef struct packed {
        lppc_pkg::win_entry_t              center;
        logic [lppc_pkg::COORD_W:0]        dn_abs;
        logic [lppc_pkg::COORD_W:0]        dp_abs;
        logic                              any;
        logic [lppc_pkg::INTENS_W-1:0]     lo;
        logic [lppc_pkg::INTENS_W-1:0]     hi;
    } s1_t;

    s1_t  s1_reg, s1_next;
    logic s1_valid_reg;
    logic out_valid_reg;
    lppc_pkg::plane_t out_reg;

    logic signed [lppc_pkg::COORD_W:0]   dn, dp;
    logic        [lppc_pkg::COORD_W+1:0] gd;
    logic        [lppc_pkg::COORD_W+1:0] gabs;
    logic        [lppc_pkg::INTENS_W-1:0] spread;
    logic advance, s1_take, planar, int_ok, grad_ok;

    // stage 1: depth deltas and intensity range
    always_comb
    begin
        dn = {cand.z_next[lppc_pkg::COORD_W-1], cand.z_next}
           - {cand.center.z[lppc_pkg::COORD_W-1], cand.center.z};
        dp = {cand.z_prev[lppc_pkg::COORD_W-1], cand.z_prev}
           - {cand.center.z[lppc_pkg::COORD_W-1], cand.center.z};
        s1_next.center = cand.center;
        s1_next.dn_abs = dn[lppc_pkg::COORD_W] ? -dn : dn;
        s1_next.dp_abs = dp[lppc_pkg::COORD_W] ? -dp : dp;
        s1_next.any    = 1'b0;
        s1_next.lo     = '0;
        s1_next.hi     = '0;
        for (int k = 0; k < lppc_pkg::WIN_LEN; k++)
        begin
            if (cand.bright[k].valid)
            begin
                if (!s1_next.any || cand.bright[k].value < s1_next.lo)
                begin
                    s1_next.lo = cand.bright[k].value;
                end
                if (!s1_next.any || cand.bright[k].value > s1_next.hi)
                begin
                    s1_next.hi = cand.bright[k].value;
                end
                s1_next.any = 1'b1;
            end
        end
    end

    // stage 2: limit compares into the output register
    always_comb
    begin
        gd      = {1'b0, s1_reg.dn_abs} - {1'b0, s1_reg.dp_abs};
        gabs    = gd[lppc_pkg::COORD_W+1] ? -gd : gd;
        spread  = s1_reg.hi - s1_reg.lo;
        int_ok  = !s1_reg.any || (spread <= intensity_limit);
        grad_ok = (gabs <= {2'b00, gradient_limit});
        planar  = int_ok && grad_ok;
    end

    assign advance  = !out_valid_reg || plane_ready;
    assign s1_take  = s1_valid_reg && advance;
    assign cand_pop = cand_avail && (!s1_valid_reg || advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || advance)
            begin
                s1_valid_reg <= cand_avail;
            end
            if (s1_take && planar)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (plane_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_pop)
        begin
            s1_reg <= s1_next;
        end
        if (s1_take && planar)
        begin
            out_reg.plane_x               <= s1_reg.center.x;
            out_reg.plane_y               <= s1_reg.center.y;
            out_reg.plane_z               <= s1_reg.center.z;
            out_reg.plane_intensity       <= s1_reg.center.intensity_valid ?
                                             s1_reg.center.intensity : '0;
            out_reg.plane_intensity_valid <= s1_reg.center.intensity_valid;
        end
    end

    assign plane       = out_reg;
    assign plane_valid = out_valid_reg;

endmodule

/* src/lidar_planar_point_classifier.sv */
// lidar planar point classifier: takes one lidar point per request on the point channel
// and keeps a five-point sliding window per region (region_start on a point restarts the
// window and the stride of 4). once the window is full, every fourth center is checked:
// the spread of valid intensities must not exceed intensity_limit (no valid intensity
// passes) and the depth gradient ||z[+2]-z|-|z[-2]-z|| must not exceed gradient_limit.
// passing centers come out on the plane channel, intensity forced to zero when invalid.
// rate is one point per clock sustained; point_ready drops only when the two-entry
// candidate queue between the window front end and the check pipeline is full.
// plane_valid rises once the request completing the window has passed the queue write on
// its accepting edge, then the range stage, then the compare into the output register.
// the user writes the limit registers (index 0 intensity_limit, 1 gradient_limit) via
// cfg_we only while idle; the block itself does not enforce it.

`include "lidar_planar_point_classifier_macros.svh"

module lidar_planar_point_classifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lppc_pkg::point_t                     point,
    input  logic                                 point_valid,
    output logic                                 point_ready,
    output lppc_pkg::plane_t                     plane,
    output logic                                 plane_valid,
    input  logic                                 plane_ready,
    input  logic                                 cfg_we,
    input  logic [lppc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lppc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // limit registers
    logic [lppc_pkg::LIMIT_I_W-1:0] intensity_limit_reg;
    logic [lppc_pkg::LIMIT_G_W-1:0] gradient_limit_reg;

    // front to queue to back
    lppc_pkg::cand_t     cand_in, cand_head;
    logic                q_push, q_pop;
    lppc_pkg::q_status_t q_status;

    // outgoing plane with an invalid intensity
    logic                plane_nan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_limit_reg <= lppc_pkg::INTENSITY_LIMIT_RST;
            gradient_limit_reg  <= lppc_pkg::GRADIENT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lppc_pkg::REG_INTENSITY_LIMIT:
                begin
                    intensity_limit_reg <= cfg_data[lppc_pkg::LIMIT_I_W-1:0];
                end
                lppc_pkg::REG_GRADIENT_LIMIT:
                begin
                    gradient_limit_reg <= cfg_data[lppc_pkg::LIMIT_G_W-1:0];
                end
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // front end takes a point whenever the queue has room
    assign point_ready = !q_status.full;

    lppc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point       (point),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .cand        (cand_in),
        .cand_push   (q_push)
    );

    lppc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_data (cand_in),
        .push      (q_push),
        .pop       (q_pop),
        .head      (cand_head),
        .status    (q_status)
    );

    lppc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cand            (cand_head),
        .cand_avail      (!q_status.empty),
        .cand_pop        (q_pop),
        .intensity_limit (intensity_limit_reg),
        .gradient_limit  (gradient_limit_reg),
        .plane           (plane),
        .plane_valid     (plane_valid),
        .plane_ready     (plane_ready)
    );

    assign plane_nan = plane_valid && !plane.plane_intensity_valid;

    // queue never overflows or underflows
    `LPPC_ASSERT_NOW(a_no_overflow, q_push, !q_status.full, "candidate pushed into full queue")
    `LPPC_ASSERT_NOW(a_no_underflow, q_pop, !q_status.empty, "candidate popped from empty queue")
    // invalid intensity leaves as zero
    `LPPC_ASSERT_NOW(a_nan_zero, plane_nan, plane.plane_intensity == '0, "nan not zeroed")
    // a candidate only ever leaves the queue with room downstream or a free stage
    `LPPC_ASSERT_NEXT(a_pop_lands, q_pop && !q_push, !q_status.full, "queue full right after pop")

endmodule

/* tb/lidar_planar_point_classifier_tb.sv */
`timescale 1ns / 100ps

module lidar_planar_point_classifier_tb;

    localparam int CLK_PERIOD    = 10;
    // margin kept after the last expected result has come out
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int STUCK_LIMIT   = 2000;

    // indexes past the last limit register, the block must ignore writes to them
    localparam logic [lppc_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [lppc_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    // one row of the directed table; typed rows carry their result written out by hand
    typedef struct {
        lppc_pkg::point_t pt;
        bit               typed;
        bit               hit;
        lppc_pkg::plane_t res;
    } stim_row_t;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    lppc_pkg::point_t                 point       = '0;
    logic                             point_valid = 1'b0;
    logic                             point_ready;
    lppc_pkg::plane_t                 plane;
    logic                             plane_valid;
    logic                             plane_ready = 1'b0;
    logic                             cfg_we      = 1'b0;
    logic [lppc_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [lppc_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;

    // classifier mirror: limits, five-point window, fill level and stride position
    logic [lppc_pkg::LIMIT_I_W-1:0]   lim_intensity = lppc_pkg::INTENSITY_LIMIT_RST;
    logic [lppc_pkg::LIMIT_G_W-1:0]   lim_gradient  = lppc_pkg::GRADIENT_LIMIT_RST;
    lppc_pkg::win_entry_t             recent_points [lppc_pkg::WIN_LEN];
    int                               points_in_window = 0;
    logic [lppc_pkg::PHASE_W-1:0]     stride_pos = '0;

    lppc_pkg::plane_t                 planes_due [$];
    stim_row_t                        directed_rows [$];

    int                               send_idle_pct  = 0;
    int                               recv_stall_pct = 0;
    bit                               hold_armed     = 1'b0;

    int                               points_sent  = 0;
    int                               regions_sent = 0;
    int                               planes_seen  = 0;
    int                               mismatches   = 0;
    int                               stuck_cycles = 0;

    lidar_planar_point_classifier i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point       (point),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .plane       (plane),
        .plane_valid (plane_valid),
        .plane_ready (plane_ready),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shift one point into the mirror window and decide whether its center is emitted
    function automatic bit classify_point(input lppc_pkg::point_t p,
                                          output lppc_pkg::plane_t res);
        int                   k;
        bit                   any_valid;
        logic [15:0]          lo;
        logic [15:0]          hi;
        longint               zc;
        longint               dn;
        longint               dp;
        longint               grad;
        bit                   tested;
        lppc_pkg::win_entry_t c;
        res = '0;
        any_valid = 1'b0;
        lo = '0;
        hi = '0;
        // a region mark restarts both the fill and the stride
        if (p.region_start)
        begin
            points_in_window = 0;
            stride_pos = '0;
        end
        for (k = 0; k < lppc_pkg::WIN_LEN - 1; k++)
            recent_points[k] = recent_points[k + 1];
        recent_points[lppc_pkg::WIN_LEN - 1].x               = p.pos_x;
        recent_points[lppc_pkg::WIN_LEN - 1].y               = p.pos_y;
        recent_points[lppc_pkg::WIN_LEN - 1].z               = p.pos_z;
        recent_points[lppc_pkg::WIN_LEN - 1].intensity       = p.intensity;
        recent_points[lppc_pkg::WIN_LEN - 1].intensity_valid = p.intensity_valid;
        if (points_in_window < lppc_pkg::WIN_LEN)
            points_in_window++;
        // window not yet full in this region: no center to look at
        if (points_in_window < lppc_pkg::WIN_LEN)
            return 1'b0;
        tested = (stride_pos == '0);
        stride_pos = stride_pos + 1'b1;
        if (!tested)
            return 1'b0;
        // spread over valid intensities only, none valid passes
        for (k = 0; k < lppc_pkg::WIN_LEN; k++)
        begin
            if (recent_points[k].intensity_valid)
            begin
                if (!any_valid || recent_points[k].intensity < lo)
                    lo = recent_points[k].intensity;
                if (!any_valid || recent_points[k].intensity > hi)
                    hi = recent_points[k].intensity;
                any_valid = 1'b1;
            end
        end
        if (any_valid && (hi - lo) > lim_intensity)
            return 1'b0;
        // depth gradient ||z[+h] - z| - |z[-h] - z||, equal to the limit passes
        zc = $signed(recent_points[lppc_pkg::HALF_WINDOW].z);
        dn = $signed(recent_points[lppc_pkg::WIN_LEN - 1].z) - zc;
        dp = $signed(recent_points[0].z) - zc;
        if (dn < 0)
            dn = -dn;
        if (dp < 0)
            dp = -dp;
        grad = dn - dp;
        if (grad < 0)
            grad = -grad;
        if (grad > longint'(lim_gradient))
            return 1'b0;
        c = recent_points[lppc_pkg::HALF_WINDOW];
        res.plane_x               = c.x;
        res.plane_y               = c.y;
        res.plane_z               = c.z;
        // an invalid intensity leaves the block as zero
        res.plane_intensity       = c.intensity_valid ? c.intensity : '0;
        res.plane_intensity_valid = c.intensity_valid;
        return 1'b1;
    endfunction

    function automatic lppc_pkg::point_t mk_point(input int x, input int y, input int z,
                                                  input int i, input bit iv, input bit rs);
        lppc_pkg::point_t p;
        p.pos_x           = x[23:0];
        p.pos_y           = y[23:0];
        p.pos_z           = z[23:0];
        p.intensity       = i[15:0];
        p.intensity_valid = iv;
        p.region_start    = rs;
        return p;
    endfunction

    function automatic lppc_pkg::plane_t mk_plane(input int x, input int y, input int z,
                                                  input int i, input bit iv);
        lppc_pkg::plane_t r;
        r.plane_x               = x[23:0];
        r.plane_y               = y[23:0];
        r.plane_z               = z[23:0];
        r.plane_intensity       = i[15:0];
        r.plane_intensity_valid = iv;
        return r;
    endfunction

    function automatic void add_row(input lppc_pkg::point_t p, input bit typed, input bit hit,
                                    input lppc_pkg::plane_t res);
        stim_row_t row;
        row.pt    = p;
        row.typed = typed;
        row.hit   = hit;
        row.res   = res;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // offer one point, wait for its request to go through, then record what must come out
    task automatic send_point(input lppc_pkg::point_t p, input bit typed, input bit typed_hit,
                              input lppc_pkg::plane_t typed_plane);
        lppc_pkg::plane_t guess;
        bit               hit;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point       <= p;
        point_valid <= 1'b1;
        do
            @(posedge clk);
        while (!point_ready);
        hit = classify_point(p, guess);
        // hand-typed rows override the mirror, the mirror still tracks the window
        if (typed)
        begin
            hit   = typed_hit;
            guess = typed_plane;
        end
        if (hit)
            planes_due.insert(planes_due.size(), guess);
        points_sent++;
    endtask

    // stop offering points and wait for the pipeline to empty, including dropped centers
    task automatic drain_planes();
        point_valid <= 1'b0;
        while (planes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lppc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lppc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == lppc_pkg::REG_INTENSITY_LIMIT)
            lim_intensity = data[lppc_pkg::LIMIT_I_W-1:0];
        else if (idx == lppc_pkg::REG_GRADIENT_LIMIT)
            lim_gradient = data[lppc_pkg::LIMIT_G_W-1:0];
    endtask

    // upper bits of the intensity write are junk and must be dropped by the block
    task automatic set_limits(input int ilim, input int glim);
        logic [lppc_pkg::CFG_DATA_W-1:0] junk;
        junk = 24'($urandom);
        write_reg(lppc_pkg::REG_INTENSITY_LIMIT,
                  {junk[lppc_pkg::CFG_DATA_W-1:lppc_pkg::LIMIT_I_W],
                   ilim[lppc_pkg::LIMIT_I_W-1:0]});
        write_reg(lppc_pkg::REG_GRADIENT_LIMIT, glim[lppc_pkg::LIMIT_G_W-1:0]);
    endtask

    // random regions: mostly filled windows, mostly smooth depth, close intensities in half of
    // them, some wild values, short regions and stray region marks
    task automatic run_phase(input int n_items);
        int               sent;
        int               len;
        int               z_mode;
        int               i_mode;
        int               k;
        int               z_base;
        int               slope;
        int               amp;
        int               i_base;
        int               amp_i;
        lppc_pkg::point_t p;
        sent = 0;
        while (sent < n_items)
        begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            z_mode = $urandom_range(0, 2);
            i_mode = $urandom_range(0, 3);
            z_base = $urandom;
            slope  = $urandom_range(0, 400);
            slope  = slope - 200;
            amp    = $urandom_range(0, 300);
            i_base = $urandom;
            amp_i  = $urandom_range(0, 100);
            regions_sent++;
            for (k = 0; k < len; k++)
            begin
                p.pos_x = 24'($urandom);
                p.pos_y = 24'($urandom);
                case (z_mode)
                    0:       p.pos_z = 24'(z_base + k * slope);
                    1:       p.pos_z = 24'(z_base + $urandom_range(0, 2 * amp) - amp);
                    default: p.pos_z = 24'($urandom);
                endcase
                case (i_mode)
                    0:
                    begin
                        p.intensity       = 16'(i_base);
                        p.intensity_valid = ($urandom_range(0, 9) != 0);
                    end
                    1:
                    begin
                        p.intensity       = 16'(i_base + $urandom_range(0, 2 * amp_i) - amp_i);
                        p.intensity_valid = ($urandom_range(0, 9) != 0);
                    end
                    2:
                    begin
                        p.intensity       = 16'($urandom);
                        p.intensity_valid = 1'($urandom);
                    end
                    default:
                    begin
                        p.intensity       = 16'($urandom);
                        p.intensity_valid = 1'b0;
                    end
                endcase
                p.region_start = (k == 0) || ($urandom_range(0, 49) == 0);
                send_point(p, 1'b0, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off when armed by the stimulus
    initial
    begin : plane_sink
        int hold_count;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                begin
                    plane_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            plane_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string what, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // every plane request is compared with the oldest outstanding prediction
    always @(posedge clk)
    begin : plane_checker
        lppc_pkg::plane_t want;
        if (rst_n && plane_valid && plane_ready)
        begin
            planes_seen++;
            if (planes_due.size() == 0)
            begin
                $display("%0t: unexpected plane, expected none, actual %h", $time, plane);
                mismatches++;
            end
            else
            begin
                want = planes_due.pop_front();
                check_field("plane_x", want.plane_x, plane.plane_x);
                check_field("plane_y", want.plane_y, plane.plane_y);
                check_field("plane_z", want.plane_z, plane.plane_z);
                check_field("plane_intensity", 24'(want.plane_intensity),
                            24'(plane.plane_intensity));
                check_field("plane_intensity_valid", 24'(want.plane_intensity_valid),
                            24'(plane.plane_intensity_valid));
            end
        end
    end

    // watchdog on cycles in which neither channel moves a request
    always @(posedge clk)
    begin
        if ((point_valid && point_ready) || (plane_valid && plane_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, stuck_cycles);
            $display("lidar_planar_point_classifier_tb failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stream before any region mark, reset limits 77 / 102; spread of exactly 77 passes
        add_row(mk_point(-8388608, 8388607, 0, 100, 1, 0), 1, 0, '0);
        add_row(mk_point(8388607, -8388608, 0, 150, 1, 0), 1, 0, '0);
        add_row(mk_point(1, -1, 0, 177, 1, 0), 1, 0, '0);
        add_row(mk_point(0, 0, 0, 65535, 0, 0), 1, 0, '0);
        add_row(mk_point(5, 5, 0, 120, 1, 0), 1, 1, mk_plane(1, -1, 0, 177, 1));
        // off-stride centers are skipped, the next on-stride one goes to the mirror
        add_row(mk_point(6, 6, 0, 130, 1, 0), 1, 0, '0);
        add_row(mk_point(7, 7, -40, 140, 1, 0), 1, 0, '0);
        add_row(mk_point(8, 8, 9, 150, 1, 0), 1, 0, '0);
        add_row(mk_point(9, 9, 30, 100, 1, 0), 0, 0, '0);
        // region shorter than the window never tests a center
        add_row(mk_point(10, 10, 0, 0, 1, 1), 1, 0, '0);
        add_row(mk_point(11, 11, 0, 0, 1, 0), 1, 0, '0);
        // no valid intensity anywhere, gradient exactly at its limit, center zeroed
        add_row(mk_point(12, 12, 0, 16'h1234, 0, 1), 1, 0, '0);
        add_row(mk_point(13, 13, 500, 16'hffff, 0, 0), 1, 0, '0);
        add_row(mk_point(-14, 14, 0, 16'habcd, 0, 0), 1, 0, '0);
        add_row(mk_point(15, 15, -999, 0, 0, 0), 1, 0, '0);
        add_row(mk_point(16, 16, 102, 16'h8000, 0, 0), 1, 1, mk_plane(-14, 14, 0, 0, 0));
        // gradient one over its limit
        add_row(mk_point(17, 17, 0, 200, 1, 1), 1, 0, '0);
        add_row(mk_point(18, 18, 0, 200, 1, 0), 1, 0, '0);
        add_row(mk_point(19, 19, 0, 200, 1, 0), 1, 0, '0);
        add_row(mk_point(20, 20, 0, 200, 1, 0), 1, 0, '0);
        add_row(mk_point(21, 21, -103, 200, 1, 0), 1, 0, '0);
        // depth extremes cancel out, but the full intensity range fails the spread
        add_row(mk_point(-8388608, -8388608, -8388608, 0, 1, 1), 1, 0, '0);
        add_row(mk_point(8388607, 8388607, 0, 0, 1, 0), 1, 0, '0);
        add_row(mk_point(-8388608, 8388607, 8388607, 0, 1, 0), 1, 0, '0);
        add_row(mk_point(8388607, -8388608, 0, 0, 1, 0), 1, 0, '0);
        add_row(mk_point(0, 0, -8388608, 65535, 1, 0), 1, 0, '0);

        for (r = 0; r < directed_rows.size(); r++)
            send_point(directed_rows[r].pt, directed_rows[r].typed, directed_rows[r].hit,
                       directed_rows[r].res);
        drain_planes();

        // moderate limits, full rate on both sides; writes to a spare index are ignored
        set_limits(200, 300);
        write_reg(REG_SPARE_2, 24'($urandom));
        run_phase(150);
        drain_planes();

        // zero limits with an idle sender: only windows with equal valid intensities and a symmetric depth get through
        send_idle_pct = 53;
        set_limits(0, 0);
        run_phase(150);
        drain_planes();

        // widest limits with a stalling receiver: every tested center comes out
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        set_limits(65535, 16777215);
        run_phase(150);
        drain_planes();

        // random limits, both sides idling
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        set_limits($urandom_range(0, 2000), $urandom_range(0, 5000));
        write_reg(REG_SPARE_3, 24'($urandom));
        run_phase(150);
        drain_planes();

        // long receiver hold-off while points keep coming, fills the candidate queue
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_limits(65535, 16777215);
        hold_armed = 1'b1;
        run_phase(150);
        drain_planes();

        if (planes_due.size() != 0)
        begin
            $display("%0t: planes still outstanding, expected 0, actual %0d", $time,
                     planes_due.size());
            mismatches++;
        end
        $display("sent %0d points (%0d random regions) under five limit settings", points_sent,
                 regions_sent);
        $display("checked %0d planes, %0d mismatches", planes_seen, mismatches);
        if (mismatches == 0)
            $display("lidar_planar_point_classifier_tb passed");
        else
            $display("lidar_planar_point_classifier_tb failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/lppc_pkg.sv
src/lppc_front.sv
src/lppc_queue.sv
src/lppc_back.sv
src/lidar_planar_point_classifier.sv
tb/lidar_planar_point_classifier_tb.sv
